FILE: src/rbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, widths and elaboration-time table builders for the Gaussian
// RBF kernel evaluator.
// ----------------------------------------------------------------------------
package rbf_pkg;

	localparam int ELEM_W   = 16;   // signed Q3.12 element
	localparam int SQ_W     = 32;   // squared difference, Q8.24
	localparam int SUM_W    = 44;   // distance sum, Q20.24
	localparam int GAMMA_W  = 16;   // unsigned Q4.12
	localparam int KV_W     = 17;   // unsigned Q1.16
	localparam int TAB_W    = 32;   // table entries, Q.31 (2^31 included)
	localparam int INT_STEPS = 16;  // integer steps of exp(-k)
	localparam int QDEPTH   = 2;    // front-to-back queue depth

	localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

	// Finished distance sum handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ovf;
	} qent_t;

	// exp(-f), f in Q.31 (0..2^31), by the alternating Taylor series, Q.31
	function automatic logic [63:0] exp_neg_series(input logic [63:0] f);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = ONE_Q31;
		pos  = ONE_Q31;
		neg  = '0;
		for (int j = 1; j <= 30; j++) begin
			if (term != 64'd0) begin
				term = ((term * f) >> 31) / 64'(j);
				if ((j & 1) != 0)
					neg = neg + term;
				else
					pos = pos + term;
			end
		end
		return pos - neg;
	endfunction

	// exp(-k) in Q.31, built by repeated rounded products with exp(-1)
	function automatic logic [63:0] exp_int_entry(input int k);
		logic [63:0] e1;
		logic [63:0] e;
		e1 = exp_neg_series(ONE_Q31);
		e  = ONE_Q31;
		for (int i = 1; i < INT_STEPS; i++) begin
			if (i <= k)
				e = (e * e1 + (ONE_Q31 >> 1)) >> 31;
		end
		return e;
	endfunction

endpackage

FILE: src/rbf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_fifo
// Short queue of finished distance sums between the accumulating front end
// and the exp back end.
// ----------------------------------------------------------------------------
module rbf_fifo import rbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  qent_t wr_data,
	output logic  wr_full,
	input  logic  rd_en,
	output qent_t rd_data,
	output logic  rd_empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	qent_t              mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_full  = (count_q == CNT_W'(QDEPTH));
	assign rd_empty = (count_q == '0);
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && !rd_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	// store words
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/rbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_front
// Accepts element pairs, squares their difference and keeps the saturating
// running sum; on the last pair hands the finished sum to the queue.
// ----------------------------------------------------------------------------
module rbf_front import rbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [ELEM_W-1:0] elem_a,
	input  logic signed [ELEM_W-1:0] elem_b,
	input  logic                     last_element,
	output logic                     q_wr,
	output qent_t                    q_data,
	input  logic                     q_full
);

	logic signed [ELEM_W-1:0] a_s1;
	logic signed [ELEM_W-1:0] b_s1;
	logic                     last_s1;
	logic                     v_s1;
	logic [SQ_W-1:0]          sq_s2;
	logic                     last_s2;
	logic                     v_s2;
	logic [SUM_W-1:0]         sum_q;
	logic                     ovf_q;

	logic                     adv1;
	logic                     adv2;
	logic                     s2_free;
	logic                     accept;
	logic signed [ELEM_W:0]   diff;
	logic [ELEM_W-1:0]        mag;
	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         sum_new;
	logic                     ovf_new;

	// stall control: a last pair waits in stage 2 while the queue is full
	assign adv2    = v_s2 && !(last_s2 && q_full);
	assign s2_free = !v_s2 || adv2;
	assign adv1    = v_s1 && s2_free;
	assign full    = v_s1 && !s2_free;
	assign accept  = push && !full;

	// square the difference; |a-b| never exceeds 65535
	always_comb begin
		diff = (ELEM_W+1)'(a_s1) - (ELEM_W+1)'(b_s1);
		mag  = diff[ELEM_W] ? ELEM_W'(-diff) : ELEM_W'(diff);
	end

	// saturate the running sum at all ones
	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_s2);
		sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
		ovf_new = ovf_q | sum_ext[SUM_W];
	end

	assign q_wr       = adv2 && last_s2;
	assign q_data.sum = sum_new;
	assign q_data.ovf = ovf_new;

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1    <= elem_a;
			b_s1    <= elem_b;
			last_s1 <= last_element;
		end
		if (adv1) begin
			sq_s2   <= SQ_W'(mag) * SQ_W'(mag);
			last_s2 <= last_s1;
		end
	end

	// stage valids and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
			if (adv2) begin
				if (last_s2) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_new;
					ovf_q <= ovf_new;
				end
			end
		end
	end

endmodule

FILE: src/rbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_back
// Sequencer that scales a finished distance sum by gamma, evaluates exp(-x)
// from the integer and interpolated fraction tables, and holds the result.
// ----------------------------------------------------------------------------
module rbf_back import rbf_pkg::*; #(
	parameter int EXP_TABLE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [GAMMA_W-1:0] gamma,
	input  qent_t              q_data,
	input  logic               q_empty,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [KV_W-1:0]    kernel_value,
	output logic               saturated
);

	localparam int TAB_AW = $clog2(EXP_TABLE_SIZE + 1);
	localparam int P_W    = 36 + TAB_AW;
	localparam int LO_W   = 22;
	localparam int HI_W   = SUM_W - LO_W;
	localparam int PR_W   = LO_W + GAMMA_W;
	localparam int X_W    = SUM_W + GAMMA_W;

	typedef enum logic [3:0] {
		B_IDLE, B_MLO, B_MHI, B_SUM, B_IDX, B_LUT, B_INTERP, B_SCALE, B_OUT
	} bstate_t;

	bstate_t            state_q;
	logic [SUM_W-1:0]   sum_q;
	logic               ovf_q;
	logic [PR_W-1:0]    prod_lo_q;
	logic [HI_W+GAMMA_W-1:0] prod_hi_q;
	logic [X_W-1:0]     x_q;
	logic [3:0]         k_q;
	logic               big_q;
	logic [P_W-1:0]     p_q;
	logic [TAB_W-1:0]   t0_q;
	logic [TAB_W-1:0]   t1_q;
	logic [30:0]        r_q;
	logic [TAB_W-1:0]   fval_q;
	logic [KV_W-1:0]    kv_q;
	logic               res_valid_q;
	logic [KV_W-1:0]    kernel_value_q;
	logic               saturated_q;

	logic [TAB_W-1:0]   frac_tab [EXP_TABLE_SIZE + 1];
	logic [TAB_W-1:0]   int_tab  [INT_STEPS];
	logic [TAB_AW-1:0]  idx0;
	logic [TAB_AW-1:0]  idx1;
	logic [TAB_W-1:0]   tdiff;
	logic [62:0]        iprod;
	logic [63:0]        scaled;
	logic               out_free;

	// constant tables, evaluated at elaboration
	for (genvar g = 0; g <= EXP_TABLE_SIZE; g++) begin : g_frac
		localparam logic [63:0] FV =
			exp_neg_series((64'(g) << 31) / 64'(EXP_TABLE_SIZE));
		assign frac_tab[g] = FV[TAB_W-1:0];
	end
	for (genvar g = 0; g < INT_STEPS; g++) begin : g_int
		localparam logic [63:0] EV = exp_int_entry(g);
		assign int_tab[g] = EV[TAB_W-1:0];
	end

	// fraction index is always below the table size, so idx1 stays in range
	assign idx0 = p_q[P_W-1:36];
	assign idx1 = idx0 + 1'b1;

	// interpolate between neighboring entries
	always_comb begin
		tdiff  = t0_q - t1_q;
		iprod  = 63'(tdiff) * 63'(r_q);
		scaled = 64'(int_tab[k_q]) * 64'(fval_q) + (64'd1 << 45);
	end

	assign out_free     = !res_valid_q || pop;
	assign q_rd         = (state_q == B_IDLE) && !q_empty;
	assign empty        = !res_valid_q;
	assign kernel_value = kernel_value_q;
	assign saturated    = saturated_q;

	// sequence one vector through scale, split, lookup, interpolate, round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// drop a taken word unless a new one replaces it this cycle
			if (pop && res_valid_q && (state_q != B_OUT))
				res_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						sum_q   <= q_data.sum;
						ovf_q   <= q_data.ovf;
						state_q <= B_MLO;
					end
				end
				B_MLO: begin
					prod_lo_q <= PR_W'(sum_q[LO_W-1:0]) * PR_W'(gamma);
					state_q   <= B_MHI;
				end
				B_MHI: begin
					prod_hi_q <= (HI_W+GAMMA_W)'(sum_q[SUM_W-1:LO_W]) *
						(HI_W+GAMMA_W)'(gamma);
					state_q   <= B_SUM;
				end
				B_SUM: begin
					x_q     <= {prod_hi_q, {LO_W{1'b0}}} + X_W'(prod_lo_q);
					state_q <= B_IDX;
				end
				B_IDX: begin
					big_q   <= |x_q[X_W-1:40];
					k_q     <= x_q[39:36];
					p_q     <= P_W'(x_q[35:0]) * P_W'(EXP_TABLE_SIZE);
					state_q <= B_LUT;
				end
				B_LUT: begin
					t0_q    <= frac_tab[idx0];
					t1_q    <= frac_tab[idx1];
					r_q     <= p_q[35:5];
					state_q <= B_INTERP;
				end
				B_INTERP: begin
					fval_q  <= t0_q - TAB_W'(iprod >> 31);
					state_q <= B_SCALE;
				end
				B_SCALE: begin
					kv_q    <= big_q ? '0 : scaled[62:46];
					state_q <= B_OUT;
				end
				B_OUT: begin
					// hold until the result register is free
					if (out_free) begin
						kernel_value_q <= kv_q;
						saturated_q    <= ovf_q;
						res_valid_q    <= 1'b1;
						state_q        <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: src/rbf_kernel_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_kernel_eval
// Gaussian RBF kernel exp(-gamma*||a-b||^2) over streamed element pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive elem_a, elem_b, last_element with push; a word is
//   taken on each edge with push high and full low. One pair per cycle is
//   taken while full stays low; last_element closes the vector.
//   Result queue: while empty is low, kernel_value and saturated show the
//   oldest result; pop high on an edge with empty low takes it.
//   Config: cfg_data is written to gamma (Q4.12) when cfg_valid is high;
//   cfg_ready is always high. Write only while the block is idle.
// Path: the last pair's sum passes two front stages into the queue, then the
//   nine back-end sequencer steps, before empty goes low.
// Throughput: the front takes one pair per cycle while full is low; the back end
//   takes a new sum only after all nine sequencer steps of the last, so vectors
//   shorter than nine pairs are paced by the back end via the two-entry sum queue.
// Reset: gamma returns to 1.0, the running sum and all queues clear.
// Stall: a held result stalls the back end, then the queue fills and full
//   rises once a further last pair waits in stage 2 with a pair behind it.
// ----------------------------------------------------------------------------
module rbf_kernel_eval import rbf_pkg::*; #(
	parameter int EXP_TABLE_SIZE = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [ELEM_W-1:0] elem_a,
	input  logic signed [ELEM_W-1:0] elem_b,
	input  logic                     last_element,
	input  logic                     pop,
	output logic                     empty,
	output logic [KV_W-1:0]          kernel_value,
	output logic                     saturated,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [GAMMA_W-1:0]       cfg_data
);

	logic [GAMMA_W-1:0] gamma_q;
	logic               q_wr;
	logic               q_full;
	logic               q_rd;
	logic               q_empty;
	qent_t              q_wdata;
	qent_t              q_rdata;

	// gamma register, reset to 1.0
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gamma_q <= GAMMA_W'(4096);
		else if (cfg_valid && cfg_ready)
			gamma_q <= cfg_data;
	end

	rbf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.elem_a       (elem_a),
		.elem_b       (elem_b),
		.last_element (last_element),
		.q_wr         (q_wr),
		.q_data       (q_wdata),
		.q_full       (q_full)
	);

	rbf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (q_wdata),
		.wr_full  (q_full),
		.rd_en    (q_rd),
		.rd_data  (q_rdata),
		.rd_empty (q_empty)
	);

	rbf_back #(
		.EXP_TABLE_SIZE (EXP_TABLE_SIZE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.gamma        (gamma_q),
		.q_data       (q_rdata),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.kernel_value (kernel_value),
		.saturated    (saturated)
	);

endmodule

FILE: src/rbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_checker
// Port-level checks for the kernel evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rbf_checker import rbf_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input logic            last_element,
	input logic            pop,
	input logic            empty,
	input logic [KV_W-1:0] kernel_value,
	input logic            saturated
);

	logic [3:0] open_q;
	logic       lst_in;
	logic       res_out;

	assign lst_in  = push && !full && last_element;
	assign res_out = pop && !empty;

	// count closed vectors whose result has not been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			open_q <= '0;
		else if (lst_in && !res_out)
			open_q <= open_q + 1'b1;
		else if (res_out && !lst_in)
			open_q <= open_q - 1'b1;
	end

	// hold a result that is not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kernel_value) && $stable(saturated)))
		else $error("result changed while waiting");

	// never exceed 1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kernel_value <= KV_W'(65536)))
		else $error("kernel value above one");

	// a result only follows a closed vector
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (open_q != 4'd0))
		else $error("result without a last element");

endmodule

bind rbf_kernel_eval rbf_checker u_chk (.*);
